// File: design/uss_pkg.sv
// ----------------------------------------------------------------------------
// uss_pkg
// shared types, codes and constants of the unipolar stepper sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package uss_pkg;

  localparam int TICKS_PER_MS = 1000;
  localparam int SETTLE_TICKS = 100;

  localparam int DIVISOR    = 360;
  localparam int SPEED_MAX  = 100;
  localparam int DELAY_STEP = 100;
  localparam int DELAY_BASE = 1000;
  localparam int PROD_W     = 48;

  // 360 = 8 * 45, the odd part is divided by reciprocal multiplication
  localparam int          DIV_ODD   = 45;
  // ceil(2^31 / 45), exact for dividends below 2^25
  localparam logic [25:0] DIV_RECIP = 26'd47721859;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_TURN   = 3'd1;
  localparam logic [2:0] OP_ROTATE = 3'd2;
  localparam logic [2:0] OP_MOVE   = 3'd3;
  localparam logic [2:0] OP_GO     = 3'd4;

  localparam logic [1:0] CFG_DIRECTION = 2'd0;
  localparam logic [1:0] CFG_HOLD      = 2'd1;
  localparam logic [1:0] CFG_SPR       = 2'd2;

  typedef struct packed {
    logic [7:0]  speed;
    logic [31:0] param;
    logic [2:0]  opcode;
  } item_t;

  typedef struct packed {
    logic       busy_res;
    logic [2:0] phase;
    logic [3:0] coils;
  } res_t;

  typedef struct packed {
    logic        direction_forward;
    logic        hold_torque;
    logic [15:0] steps_per_rev;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              cancel;
    logic [PROD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] steps;
  } div_rsp_t;

  function automatic logic [3:0] half_step(input logic [2:0] idx);
    logic [3:0] c;
    unique case (idx)
      3'd0: c = 4'h8;
      3'd1: c = 4'hC;
      3'd2: c = 4'h4;
      3'd3: c = 4'h6;
      3'd4: c = 4'h2;
      3'd5: c = 4'h3;
      3'd6: c = 4'h1;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/uss_div.sv
// ----------------------------------------------------------------------------
// uss_div
// divide by the degrees of a turn in four short stages by reciprocal
// multiplication, saturated to 32 bits and returned less the first step
// already taken
// ----------------------------------------------------------------------------
`default_nettype none

module uss_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire uss_pkg::div_req_t req,
  output uss_pkg::div_rsp_t      rsp
);

  // low three bits drop out, the rest is split into a high and a low half
  logic [44:0] x;
  logic [3:0]  vld;
  logic        done;

  logic        sat1, sat2, sat3, sat4;
  logic [18:0] hi1, hi2;
  logic [18:0] lo1, lo2;
  logic [13:0] qhi2;
  logic [12:0] qhi3, qhi4;
  logic [24:0] n3;
  logic [18:0] qlo4;
  logic [31:0] steps;

  logic [44:0] mul_hi;
  logic [19:0] mul_r;
  logic [19:0] rem;
  logic [50:0] mul_lo;

  always_comb begin
    x      = req.dividend[uss_pkg::PROD_W-1:3];
    mul_hi = 45'(hi1) * 45'(uss_pkg::DIV_RECIP);
    mul_r  = 20'(qhi2) * 20'(uss_pkg::DIV_ODD);
    rem    = 20'(hi2) - mul_r;
    mul_lo = 51'(n3) * 51'(uss_pkg::DIV_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      vld  <= 4'b0001;
      done <= 1'b0;
    end else if (req.cancel) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[2:0], 1'b0};
      done <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sat1 <= x[44:32] >= 13'(uss_pkg::DIV_ODD);
      hi1  <= x[37:19];
      lo1  <= x[18:0];
    end
    sat2  <= sat1;
    hi2   <= hi1;
    lo2   <= lo1;
    qhi2  <= mul_hi[44:31];
    sat3  <= sat2;
    qhi3  <= qhi2[12:0];
    n3    <= {rem[5:0], lo2};
    sat4  <= sat3;
    qhi4  <= qhi3;
    qlo4  <= mul_lo[49:31];
    steps <= (sat4 ? 32'hFFFF_FFFF : {qhi4, qlo4}) - 32'd1;
  end

  assign rsp.done  = done;
  assign rsp.steps = steps;

endmodule

`default_nettype wire

// File: design/uss_engine.sv
// ----------------------------------------------------------------------------
// uss_engine
// run state of the sequencer and the next-state logic for one item
// ----------------------------------------------------------------------------
`default_nettype none

module uss_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire uss_pkg::item_t    item,
  input  wire uss_pkg::cfg_t     cfg,
  input  wire uss_pkg::div_rsp_t div_rsp,
  output uss_pkg::res_t          res,
  output uss_pkg::div_req_t      div_req
);

  localparam logic [1:0] MODE_TURN = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_GO   = 2'd2;

  logic [2:0]  phase_index, phase_index_next;
  logic [3:0]  coil_latch, coil_latch_next;
  logic        running, running_next;
  logic [1:0]  run_mode, run_mode_next;
  logic [31:0] steps_left, steps_left_next;
  logic [13:0] delay_count, delay_count_next;
  logic [13:0] delay_reload, delay_reload_next;
  logic [9:0]  ms_prescale, ms_prescale_next;
  logic [31:0] elapsed_ms, elapsed_ms_next;
  logic [31:0] duration_ms, duration_ms_next;
  logic [6:0]  settle_count, settle_count_next;

  logic                       chk;
  logic                       go_on;
  logic                       start;
  logic                       start_rot;
  logic [10:0]                pre_inc;
  logic [6:0]                 slack;
  logic [13:0]                reload;
  logic [uss_pkg::PROD_W-1:0] prod;

  always_comb begin
    phase_index_next  = phase_index;
    coil_latch_next   = coil_latch;
    running_next      = running;
    run_mode_next     = run_mode;
    steps_left_next   = steps_left;
    delay_count_next  = delay_count;
    delay_reload_next = delay_reload;
    ms_prescale_next  = ms_prescale;
    elapsed_ms_next   = elapsed_ms;
    duration_ms_next  = duration_ms;
    settle_count_next = settle_count;

    chk       = 1'b0;
    go_on     = 1'b0;
    start     = 1'b0;
    start_rot = 1'b0;
    pre_inc   = {1'b0, ms_prescale} + 11'd1;
    slack     = 7'(8'(uss_pkg::SPEED_MAX) - item.speed);
    reload    = 14'(slack) * 14'(uss_pkg::DELAY_STEP) + 14'(uss_pkg::DELAY_BASE);
    prod      = uss_pkg::PROD_W'(cfg.steps_per_rev) * uss_pkg::PROD_W'(item.param);

    unique case (item.opcode)
      uss_pkg::OP_TICK: begin
        if (running) begin
          if (run_mode == MODE_MOVE) begin
            if (pre_inc >= 11'(uss_pkg::TICKS_PER_MS)) begin
              ms_prescale_next = '0;
              if (elapsed_ms != '1) elapsed_ms_next = elapsed_ms + 32'd1;
            end else begin
              ms_prescale_next = pre_inc[9:0];
            end
          end
          if (delay_count != '0) delay_count_next = delay_count - 14'd1;
          if (delay_count_next == '0) begin
            chk = 1'b1;
            priority case (run_mode)
              MODE_TURN: go_on = steps_left != '0;
              MODE_MOVE: go_on = elapsed_ms_next < duration_ms;
              default:   go_on = 1'b1;
            endcase
          end
        end else if (settle_count != '0) begin
          settle_count_next = settle_count - 7'd1;
          if (settle_count_next == '0) coil_latch_next = '0;
        end
      end
      uss_pkg::OP_TURN, uss_pkg::OP_ROTATE, uss_pkg::OP_MOVE, uss_pkg::OP_GO: begin
        if (!running && item.speed <= 8'(uss_pkg::SPEED_MAX)) begin
          if (item.speed == '0) begin
            chk   = 1'b1;
            go_on = 1'b0;
          end else begin
            start             = 1'b1;
            chk               = 1'b1;
            running_next      = 1'b1;
            elapsed_ms_next   = '0;
            ms_prescale_next  = '0;
            settle_count_next = '0;
            delay_reload_next = reload;
            unique case (item.opcode)
              uss_pkg::OP_TURN: begin
                run_mode_next    = MODE_TURN;
                steps_left_next  = item.param;
                duration_ms_next = item.param;
                go_on            = item.param != '0;
              end
              uss_pkg::OP_ROTATE: begin
                start_rot        = 1'b1;
                run_mode_next    = MODE_TURN;
                steps_left_next  = '0;
                duration_ms_next = '0;
                go_on            = prod >= uss_pkg::PROD_W'(uss_pkg::DIVISOR);
              end
              uss_pkg::OP_MOVE: begin
                run_mode_next    = MODE_MOVE;
                steps_left_next  = item.param;
                duration_ms_next = item.param;
                go_on            = item.param != '0;
              end
              default: begin
                run_mode_next    = MODE_GO;
                steps_left_next  = '0;
                duration_ms_next = '0;
                go_on            = 1'b1;
              end
            endcase
          end
        end
      end
      default: begin
        chk   = 1'b1;
        go_on = 1'b0;
      end
    endcase

    if (chk) begin
      if (go_on) begin
        phase_index_next = cfg.direction_forward ? phase_index + 3'd1 : phase_index - 3'd1;
        coil_latch_next  = uss_pkg::half_step(phase_index_next);
        if (run_mode_next == MODE_TURN) steps_left_next = steps_left_next - 32'd1;
        delay_count_next = delay_reload_next;
      end else begin
        running_next     = 1'b0;
        delay_count_next = '0;
        if (!cfg.hold_torque) begin
          if (uss_pkg::SETTLE_TICKS == 0) begin
            coil_latch_next   = '0;
            settle_count_next = '0;
          end else begin
            settle_count_next = 7'(uss_pkg::SETTLE_TICKS);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index  <= '0;
      coil_latch   <= '0;
      running      <= 1'b0;
      run_mode     <= MODE_TURN;
      steps_left   <= '0;
      delay_count  <= '0;
      delay_reload <= '0;
      ms_prescale  <= '0;
      elapsed_ms   <= '0;
      duration_ms  <= '0;
      settle_count <= '0;
    end else begin
      if (advance) begin
        phase_index  <= phase_index_next;
        coil_latch   <= coil_latch_next;
        running      <= running_next;
        run_mode     <= run_mode_next;
        delay_count  <= delay_count_next;
        delay_reload <= delay_reload_next;
        ms_prescale  <= ms_prescale_next;
        elapsed_ms   <= elapsed_ms_next;
        duration_ms  <= duration_ms_next;
        settle_count <= settle_count_next;
      end
      if (div_rsp.done && !(advance && start)) begin
        steps_left <= div_rsp.steps;
      end else if (advance) begin
        steps_left <= steps_left_next;
      end
    end
  end

  assign res.coils    = coil_latch_next;
  assign res.phase    = phase_index_next;
  assign res.busy_res = running_next;

  assign div_req.start    = advance && start_rot;
  assign div_req.cancel   = advance && start;
  assign div_req.dividend = prod;

endmodule

`default_nettype wire

// File: design/unipolar_stepper_sequencer_core.sv
// ----------------------------------------------------------------------------
// unipolar_stepper_sequencer_core
// four-coil unipolar stepper driver on the eight-phase half-step table
//
//   channel   direction   handshake                 payload
//   s_*       in          s_tvalid / s_tready       s_tdata: opcode, param, speed
//   m_*       out         m_tvalid / m_tready       m_tdata: coils, phase, busy_res
//   cfg_*     in          cfg_we                    cfg_index, cfg_data
//
// one item per cycle while m_tready is high: an item taken into the input register
// is worked into the result register on advance, and its result is then offered on m_*
// a rotate step count from uss_div reaches the step counter through the divider stages,
// well inside the first step interval of at least 1000 ticks
// rst is synchronous and clears the run state and the valid flags of both registers
// a waiting result holds m_tdata while one more item is taken into s side
// ----------------------------------------------------------------------------
`default_nettype none

module unipolar_stepper_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // opcode[2:0], param[34:3], speed[42:35], zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // coils[3:0], phase[6:4], busy_res[7]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic              in_valid;
  uss_pkg::item_t    in_item;
  logic              out_valid;
  uss_pkg::res_t     out_res;
  uss_pkg::cfg_t     cfg;

  logic              advance;
  uss_pkg::res_t     res;
  uss_pkg::div_req_t div_req;
  uss_pkg::div_rsp_t div_rsp;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_item.opcode <= s_tdata[2:0];
      in_item.param  <= s_tdata[34:3];
      in_item.speed  <= s_tdata[42:35];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction_forward <= 1'b1;
      cfg.hold_torque       <= 1'b0;
      cfg.steps_per_rev     <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uss_pkg::CFG_DIRECTION: cfg.direction_forward <= cfg_data[0];
        uss_pkg::CFG_HOLD:      cfg.hold_torque       <= cfg_data[0];
        uss_pkg::CFG_SPR:       cfg.steps_per_rev     <= cfg_data;
        default: ;
      endcase
    end
  end

  uss_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .div_rsp (div_rsp),
    .res     (res),
    .div_req (div_req)
  );

  uss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.busy_res, out_res.phase, out_res.coils};

endmodule

`default_nettype wire
